>>> hdl/least_loaded_bin_assigner_macros.svh
// Assertion macros shared by the bin assigner modules.
// Both sample on clk and are disabled during rst.
`ifndef LEAST_LOADED_BIN_ASSIGNER_MACROS_SVH
`define LEAST_LOADED_BIN_ASSIGNER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LLBA_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llba check failed");

// Consequent must hold in the cycle after the antecedent.
`define LLBA_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llba check failed");

`endif

>>> hdl/llba_pkg.sv
package llba_pkg;

  localparam int LOAD_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int NB_W      = 5;
  localparam int OUT_IDX_W = 4;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
  localparam logic [NB_W-1:0]   NB_RESET = NB_W'(16);

  typedef struct packed {
    logic fire;
    logic clear;
    logic shift;
    logic take_new;
  } cell_ctl_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] bin_index;
    logic [LOAD_W-1:0]    bin_load;
    logic                 saturated;
  } res_t;

endpackage

>>> hdl/llba_in_if.sv
interface llba_in_if import llba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] job_size;
  logic              new_set;

  modport source (output valid, job_size, new_set, input ready);
  modport sink (input valid, job_size, new_set, output ready);
endinterface

>>> hdl/llba_out_if.sv
interface llba_out_if import llba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] bin_index;
  logic [LOAD_W-1:0]    bin_load;
  logic                 saturated;

  modport source (output valid, bin_index, bin_load, saturated, input ready);
  modport sink (input valid, bin_index, bin_load, saturated, output ready);
endinterface

>>> hdl/llba_cfg_if.sv
interface llba_cfg_if import llba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [NB_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hdl/llba_cell.sv
module llba_cell import llba_pkg::*; #(
  parameter int IW  = 4,
  parameter int POS = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic [LOAD_W-1:0] nxt_load,
  input  logic [IW-1:0]     nxt_idx,
  input  logic [LOAD_W-1:0] new_load,
  input  logic [IW-1:0]     new_idx,
  output logic [LOAD_W-1:0] view_load,
  output logic [IW-1:0]     view_idx,
  output logic              lt_new
);

  logic [LOAD_W-1:0] load;
  logic [IW-1:0]     idx;

  assign view_load = ctl.clear ? '0 : load;
  assign view_idx  = ctl.clear ? IW'(POS) : idx;
  assign lt_new    = {view_load, view_idx} < {new_load, new_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      load <= '0;
      idx  <= IW'(POS);
    end else if (ctl.fire) begin
      if (ctl.take_new) begin
        load <= new_load;
        idx  <= new_idx;
      end else if (ctl.shift) begin
        load <= nxt_load;
        idx  <= nxt_idx;
      end else begin
        load <= view_load;
        idx  <= view_idx;
      end
    end
  end

endmodule

>>> hdl/llba_obuf.sv
`include "least_loaded_bin_assigner_macros.svh"

module llba_obuf import llba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic ready,
  llba_out_if.source out
);

  logic out_v;
  logic skid_v;
  res_t out_d;
  res_t skid_d;
  logic open_out;

  assign ready    = !skid_v;
  assign open_out = !out_v || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (open_out) begin
      out_v  <= skid_v || push;
      skid_v <= 1'b0;
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (open_out) begin
      out_d <= skid_v ? skid_d : push_data;
    end else if (push) begin
      skid_d <= push_data;
    end
  end

  assign out.valid     = out_v;
  assign out.bin_index = out_d.bin_index;
  assign out.bin_load  = out_d.bin_load;
  assign out.saturated = out_d.saturated;

  `LLBA_CHECK_NOW(a_skid_behind_out, skid_v, out_v)
  `LLBA_CHECK_NEXT(a_push_to_empty, push && !out_v, out_v && !skid_v)
  `LLBA_CHECK_NEXT(a_skid_drains, skid_v && out.ready, out_v && !skid_v)

endmodule

>>> hdl/least_loaded_bin_assigner.sv
// Least-loaded bin assigner.
// in  (sink):   beats carry job_size and new_set; a beat moves on valid && ready.
// out (source): one beat per input beat with bin_index, bin_load, saturated,
//               in input order.
// cfg (sink):   one register, num_bins; always ready. Write only while idle.
// The bins live in a row of cells kept sorted by (load, bin). The chosen bin
// is the first cell whose bin is in use; it is pulled out, its load updated
// with saturation at all ones, and reinserted while the cells behind it shift
// one place toward the head, all in the same cycle.
// The result beat is registered in the output buffer before it is shown on out.
// Throughput: one beat per cycle while in.ready is high; the row takes each insert as it fires.
// Stall: a two-entry output buffer holds results; in.ready falls only when
// both entries are full, and no beat is dropped or repeated.
// Reset (rst, synchronous): all loads zero, cells in bin order, num_bins 16,
// output buffer empty. new_set clears all loads before placing its job.
`include "least_loaded_bin_assigner_macros.svh"

module least_loaded_bin_assigner import llba_pkg::*; #(
  parameter int MAX_BINS = 16
) (
  input logic clk,
  input logic rst,
  llba_in_if.sink    in,
  llba_out_if.source out,
  llba_cfg_if.sink   cfg
);

  localparam int IW = $clog2(MAX_BINS);
  localparam int CW = (IW > NB_W) ? IW : NB_W;

  logic [NB_W-1:0]   num_bins;
  logic              fire;
  logic              clear;
  logic [LOAD_W-1:0] vload [MAX_BINS];
  logic [IW-1:0]     vidx  [MAX_BINS];
  logic              lt    [MAX_BINS];
  logic [MAX_BINS-1:0] act;
  logic [IW-1:0]     k;
  logic [LOAD_W-1:0] sel_load;
  logic [IW-1:0]     sel_idx;
  logic [LOAD_W:0]   sum;
  logic              sat;
  logic [LOAD_W-1:0] new_load;
  res_t              res;
  logic              buf_ready;
  cell_ctl_t         ctl [MAX_BINS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins <= NB_RESET;
    end else if (cfg.valid) begin
      num_bins <= cfg.data;
    end
  end

  assign in.ready = buf_ready;
  assign fire     = in.valid && buf_ready;
  assign clear    = fire && in.new_set;

  always_comb begin
    for (int j = 0; j < MAX_BINS; j++) begin
      act[j] = (CW'(vidx[j]) < CW'(num_bins)) || (vidx[j] == '0);
    end
  end

  always_comb begin
    k = '0;
    for (int j = MAX_BINS - 1; j >= 0; j--) begin
      if (act[j]) begin
        k = IW'(j);
      end
    end
  end

  assign sel_load = vload[k];
  assign sel_idx  = vidx[k];
  assign sum      = {1'b0, sel_load} + (LOAD_W + 1)'(in.job_size);
  assign sat      = sum[LOAD_W];
  assign new_load = sat ? LOAD_MAX : sum[LOAD_W-1:0];

  genvar g;
  generate
    for (g = 0; g < MAX_BINS; g++) begin : g_cell
      logic              ge_k;
      logic              lt_up;
      logic [LOAD_W-1:0] n_load;
      logic [IW-1:0]     n_idx;

      assign ge_k = (IW'(g) >= k);

      if (g == MAX_BINS - 1) begin : g_tail
        assign lt_up  = 1'b0;
        assign n_load = new_load;
        assign n_idx  = sel_idx;
      end else begin : g_body
        assign lt_up  = lt[g+1];
        assign n_load = vload[g+1];
        assign n_idx  = vidx[g+1];
      end

      assign ctl[g].fire     = fire;
      assign ctl[g].clear    = clear;
      assign ctl[g].shift    = ge_k && lt_up;
      assign ctl[g].take_new = ge_k && !lt_up && ((IW'(g) == k) || lt[g]);

      llba_cell #(
        .IW  (IW),
        .POS (g)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl[g]),
        .nxt_load  (n_load),
        .nxt_idx   (n_idx),
        .new_load  (new_load),
        .new_idx   (sel_idx),
        .view_load (vload[g]),
        .view_idx  (vidx[g]),
        .lt_new    (lt[g])
      );
    end
  endgenerate

  assign res.bin_index = OUT_IDX_W'(sel_idx);
  assign res.bin_load  = new_load;
  assign res.saturated = sat;

  llba_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (res),
    .ready     (buf_ready),
    .out       (out)
  );

  `LLBA_CHECK_NOW(a_new_set_bin0, clear, sel_idx == '0)
  `LLBA_CHECK_NOW(a_pick_in_use, fire && (sel_idx != '0), CW'(sel_idx) < CW'(num_bins))
  `LLBA_CHECK_NOW(a_head_sorted, !clear, {vload[0], vidx[0]} < {vload[1], vidx[1]})

endmodule
